/* rtl/core/wlan_frame_eapol_beacon_filter_macros.svh */
// assertion macros shared by the frame filter rtl
`ifndef WLAN_FRAME_EAPOL_BEACON_FILTER_MACROS_SVH
`define WLAN_FRAME_EAPOL_BEACON_FILTER_MACROS_SVH

// same-cycle implication, quiet during reset
`define WFEB_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define WFEB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/wfeb_pkg.sv */
// types, constants and helpers of the 802.11 beacon and eapol frame filter
`default_nettype none

package wfeb_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int FRAME_MAX_DEF   = 512;
    localparam int LIMIT_HARD_MAX  = 1022;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 10;
    localparam int HDR_W     = 5;
    localparam int SLOT_OUT_W = 4;
    localparam int TLIM_W    = 5;
    localparam int BSSID_W   = 48;
    localparam int LLC_W     = 32;
    localparam int FC_W      = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic [TLIM_W-1:0] TARGET_LIMIT_RST = 5'd16;
    localparam logic [LEN_W-1:0]  MAX_LEN_RST      = 10'd512;

    // frame control fields
    localparam logic [FC_W-1:0] FC_TYPE_MASK = 16'h000C;
    localparam logic [FC_W-1:0] FC_SUB_MASK  = 16'h00F0;
    localparam logic [FC_W-1:0] FC_QOS       = 16'h0080;
    localparam logic [FC_W-1:0] FC_TO_DS     = 16'h0100;
    localparam logic [FC_W-1:0] FC_FROM_DS   = 16'h0200;
    localparam logic [FC_W-1:0] FC_HT_ORDER  = 16'h8000;
    localparam logic [1:0]      FTYPE_MGMT   = 2'd0;
    localparam logic [1:0]      FTYPE_DATA   = 2'd2;
    localparam logic [3:0]      FSUB_BEACON  = 4'h8;

    localparam int BSSID_FIRST  = 16;
    localparam int MIN_FRAME    = 24;
    localparam int HDR_BASE     = 24;
    localparam int LLC_LEN      = 8;

    localparam logic [LLC_W-1:0] LLC_EAPOL = {8'hAA, 8'hAA, 8'h88, 8'h8E};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_LIMIT     = 1'b0,
        CFG_MAX_FRAME_LENGTH = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        VERDICT_SHORT      = 3'd0,
        VERDICT_TOO_LONG   = 3'd1,
        VERDICT_OTHER_TYPE = 3'd2,
        VERDICT_WDS        = 3'd3,
        VERDICT_NOT_EAPOL  = 3'd4,
        VERDICT_TABLE_FULL = 3'd5,
        VERDICT_BEACON     = 3'd6,
        VERDICT_EAPOL      = 3'd7
    } t_verdict;

    typedef struct packed {
        logic hit;
        logic full;
        logic learn;
    } t_tbl_status;

    // 24, plus 2 for qos, plus 4 for ht control
    function automatic logic [HDR_W-1:0] hdr_len(input logic [FC_W-1:0] fc);
        logic [HDR_W-1:0] h;
        h = HDR_W'(HDR_BASE) + HDR_W'({(fc & FC_HT_ORDER) != '0, (fc & FC_QOS) != '0, 1'b0});
        return h;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/wfeb_if.sv */
// channel interfaces of the frame filter: byte input, verdict output, config write
`default_nettype none

interface wfeb_in_if;
    logic                          valid;
    logic                          ready;
    logic [wfeb_pkg::BYTE_W-1:0]   frame_byte;
    logic                          end_of_frame;

    modport source (output valid, output frame_byte, output end_of_frame, input ready);
    modport sink   (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

interface wfeb_out_if;
    logic                              valid;
    logic                              ready;
    wfeb_pkg::t_verdict                verdict;
    logic [wfeb_pkg::LEN_W-1:0]        frame_length;
    logic [wfeb_pkg::HDR_W-1:0]        header_length;
    logic [wfeb_pkg::SLOT_OUT_W-1:0]   table_slot;

    modport source (output valid, output verdict, output frame_length,
                    output header_length, output table_slot, input ready);
    modport sink   (input valid, input verdict, input frame_length,
                    input header_length, input table_slot, output ready);
endinterface

interface wfeb_cfg_if;
    logic                              valid;
    logic                              ready;
    wfeb_pkg::t_cfg_index              index;
    logic [wfeb_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/wlan_frame_eapol_beacon_filter.sv */
// top level of the 802.11 beacon and eapol frame filter
//
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    frame_byte[7:0], end_of_frame
//  o_out    out  valid/ready    verdict[2:0], frame_length[9:0], header_length[4:0],
//                               table_slot[3:0]
//  i_cfg    in   valid/ready    index (0 target_limit, 1 max_frame_length), data[9:0]
//
//  one byte item per cycle while i_in is not stalled; a verdict item is offered from
//  the result register in the cycle after the last byte of its frame is taken
//  the only path is frame state plus incoming byte -> bssid compare / header checks
//  -> result register; the table lookup is one 48-bit compare per entry
//  i_in stalls only while a verdict waits in the result register and o_out is held
//  synchronous active-low reset: empty table, empty frame state, config to defaults
`default_nettype none

`include "wlan_frame_eapol_beacon_filter_macros.svh"

module wlan_frame_eapol_beacon_filter #(
    parameter int TABLE_DEPTH = wfeb_pkg::TABLE_DEPTH_DEF,
    parameter int FRAME_MAX   = wfeb_pkg::FRAME_MAX_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    wfeb_in_if.sink        i_in,
    wfeb_out_if.source     o_out,
    wfeb_cfg_if.sink       i_cfg
);

    localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
    localparam int LIMIT_CAP = (FRAME_MAX < wfeb_pkg::LIMIT_HARD_MAX) ?
                               FRAME_MAX : wfeb_pkg::LIMIT_HARD_MAX;
    localparam int LEN_W = wfeb_pkg::LEN_W;

    // configuration registers
    logic [wfeb_pkg::TLIM_W-1:0] r_target_limit;
    logic [LEN_W-1:0]            r_max_len;

    // per-frame state
    logic [LEN_W-1:0]                 r_count,  n_count;
    logic [wfeb_pkg::FC_W-1:0]        r_fc,     n_fc;
    logic [wfeb_pkg::BSSID_W-1:0]     r_bssid,  n_bssid;
    logic [wfeb_pkg::LLC_W-1:0]       r_llc,    n_llc;

    // state after the current byte, before the end-of-frame clear
    logic [LEN_W-1:0]                 w_upd_count;
    logic [wfeb_pkg::FC_W-1:0]        w_upd_fc;
    logic [wfeb_pkg::BSSID_W-1:0]     w_upd_bssid;
    logic [wfeb_pkg::LLC_W-1:0]       w_upd_llc;

    // result register
    logic                             r_out_valid;
    wfeb_pkg::t_verdict               r_verdict,  n_verdict;
    logic [LEN_W-1:0]                 r_flen;
    logic [wfeb_pkg::HDR_W-1:0]       r_hlen,     n_hlen;
    logic [wfeb_pkg::SLOT_OUT_W-1:0]  r_slot,     n_slot;

    logic                        w_in_ready;
    logic                        w_take;
    logic                        w_take_last;
    logic [LEN_W-1:0]            w_limit;
    logic                        w_counting;
    logic [wfeb_pkg::HDR_W-1:0]  w_cap_hdr;
    logic [LEN_W-1:0]            w_cap_hdr_ext;
    logic [1:0]                  w_ftype;
    logic [3:0]                  w_fsub;
    logic [wfeb_pkg::HDR_W-1:0]  w_data_hdr;
    logic                        w_is_beacon;
    logic                        w_len_ok;
    logic                        w_commit;

    wfeb_pkg::t_tbl_status       w_tbl;
    logic [SLOT_W-1:0]           w_tbl_slot;
    logic [FILL_W-1:0]           w_fill;

    // input side keeps moving while the result register drains
    assign w_in_ready  = !r_out_valid || o_out.ready;
    assign i_in.ready  = w_in_ready;
    assign w_take      = i_in.valid && w_in_ready;
    assign w_take_last = w_take && i_in.end_of_frame;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_limit <= wfeb_pkg::TARGET_LIMIT_RST;
            r_max_len      <= wfeb_pkg::MAX_LEN_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                wfeb_pkg::CFG_TARGET_LIMIT: begin
                    r_target_limit <= i_cfg.data[wfeb_pkg::TLIM_W-1:0];
                end
                wfeb_pkg::CFG_MAX_FRAME_LENGTH: begin
                    r_max_len <= i_cfg.data[LEN_W-1:0];
                end
            endcase
        end
    end

    // length limit clamped to the build maximum
    always_comb begin
        if (r_max_len > LEN_W'(LIMIT_CAP)) begin
            w_limit = LEN_W'(LIMIT_CAP);
        end else begin
            w_limit = r_max_len;
        end
        w_counting = r_count <= w_limit;
    end

    // byte capture: frame control, bssid, and the llc/snap bytes after the header
    always_comb begin
        w_upd_count   = r_count;
        w_upd_fc      = r_fc;
        w_upd_bssid   = r_bssid;
        w_upd_llc     = r_llc;
        w_cap_hdr     = wfeb_pkg::hdr_len(r_fc);
        w_cap_hdr_ext = LEN_W'(w_cap_hdr);
        if (w_counting) begin
            w_upd_count = r_count + LEN_W'(1);
            if (r_count == LEN_W'(0)) begin
                w_upd_fc[7:0] = i_in.frame_byte;
            end
            if (r_count == LEN_W'(1)) begin
                w_upd_fc[15:8] = i_in.frame_byte;
            end
            // bssid arrives most significant byte first
            for (int k = 0; k < 6; k++) begin
                if (r_count == LEN_W'(wfeb_pkg::BSSID_FIRST + k)) begin
                    w_upd_bssid[wfeb_pkg::BSSID_W-1-8*k -: 8] = i_in.frame_byte;
                end
            end
            if (r_count >= LEN_W'(2)) begin
                if (r_count == w_cap_hdr_ext) begin
                    w_upd_llc[31:24] = i_in.frame_byte;
                end
                if (r_count == w_cap_hdr_ext + LEN_W'(1)) begin
                    w_upd_llc[23:16] = i_in.frame_byte;
                end
                if (r_count == w_cap_hdr_ext + LEN_W'(6)) begin
                    w_upd_llc[15:8] = i_in.frame_byte;
                end
                if (r_count == w_cap_hdr_ext + LEN_W'(7)) begin
                    w_upd_llc[7:0] = i_in.frame_byte;
                end
            end
        end
    end

    // frame classification on the final byte
    always_comb begin
        w_ftype     = 2'((w_upd_fc & wfeb_pkg::FC_TYPE_MASK) >> 2);
        w_fsub      = 4'((w_upd_fc & wfeb_pkg::FC_SUB_MASK) >> 4);
        w_data_hdr  = wfeb_pkg::hdr_len(w_upd_fc);
        w_is_beacon = (w_ftype == wfeb_pkg::FTYPE_MGMT) && (w_fsub == wfeb_pkg::FSUB_BEACON);
        w_len_ok    = (w_upd_count >= LEN_W'(wfeb_pkg::MIN_FRAME)) && (w_upd_count <= w_limit);
        w_commit    = w_take_last && w_len_ok && w_is_beacon;
    end

    wfeb_bssid_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_key          (w_upd_bssid),
        .i_target_limit (r_target_limit),
        .i_commit       (w_commit),
        .o_status       (w_tbl),
        .o_slot         (w_tbl_slot),
        .o_fill         (w_fill)
    );

    always_comb begin
        n_hlen = '0;
        n_slot = '0;
        priority if (w_upd_count < LEN_W'(wfeb_pkg::MIN_FRAME)) begin
            n_verdict = wfeb_pkg::VERDICT_SHORT;
        end else if (w_upd_count > w_limit) begin
            n_verdict = wfeb_pkg::VERDICT_TOO_LONG;
        end else if (w_is_beacon) begin
            if (w_tbl.hit || !w_tbl.full) begin
                n_verdict = wfeb_pkg::VERDICT_BEACON;
                n_slot    = wfeb_pkg::SLOT_OUT_W'(w_tbl_slot);
            end else begin
                n_verdict = wfeb_pkg::VERDICT_TABLE_FULL;
            end
        end else if (w_ftype == wfeb_pkg::FTYPE_DATA) begin
            if (((w_upd_fc & wfeb_pkg::FC_TO_DS) != '0) &&
                ((w_upd_fc & wfeb_pkg::FC_FROM_DS) != '0)) begin
                n_verdict = wfeb_pkg::VERDICT_WDS;
            end else begin
                n_hlen = w_data_hdr;
                if (w_upd_count < LEN_W'(w_data_hdr) + LEN_W'(wfeb_pkg::LLC_LEN)) begin
                    n_verdict = wfeb_pkg::VERDICT_NOT_EAPOL;
                end else if (w_upd_llc == wfeb_pkg::LLC_EAPOL) begin
                    n_verdict = wfeb_pkg::VERDICT_EAPOL;
                end else begin
                    n_verdict = wfeb_pkg::VERDICT_NOT_EAPOL;
                end
            end
        end else begin
            n_verdict = wfeb_pkg::VERDICT_OTHER_TYPE;
        end
    end

    // frame state restarts after the final byte
    always_comb begin
        if (i_in.end_of_frame) begin
            n_count = '0;
            n_fc    = '0;
            n_bssid = '0;
            n_llc   = '0;
        end else begin
            n_count = w_upd_count;
            n_fc    = w_upd_fc;
            n_bssid = w_upd_bssid;
            n_llc   = w_upd_llc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_fc    <= '0;
            r_bssid <= '0;
            r_llc   <= '0;
        end else if (w_take) begin
            r_count <= n_count;
            r_fc    <= n_fc;
            r_bssid <= n_bssid;
            r_llc   <= n_llc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_last) begin
            r_verdict <= n_verdict;
            r_flen    <= w_upd_count;
            r_hlen    <= n_hlen;
            r_slot    <= n_slot;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.verdict       = r_verdict;
    assign o_out.frame_length  = r_flen;
    assign o_out.header_length = r_hlen;
    assign o_out.table_slot    = r_slot;

    // table only grows when a beacon is learned
    `WFEB_ASSERT_NEXT(a_fill_only_on_learn, !w_tbl.learn, w_fill == $past(w_fill), "table fill changed without a learn")
    `WFEB_ASSERT_IMPL(a_short_len, o_out.valid && (o_out.verdict == wfeb_pkg::VERDICT_SHORT), o_out.frame_length < LEN_W'(wfeb_pkg::MIN_FRAME), "short verdict with long frame")
    `WFEB_ASSERT_IMPL(a_hdr_data_only, o_out.valid && (o_out.header_length != '0), (o_out.verdict == wfeb_pkg::VERDICT_EAPOL) || (o_out.verdict == wfeb_pkg::VERDICT_NOT_EAPOL), "header length on a non-data verdict")

endmodule

`default_nettype wire

/* rtl/core/wfeb_bssid_table.sv */
// bssid table: parallel lookup against learned entries and learning of new ones
`default_nettype none

module wfeb_bssid_table #(
    parameter int TABLE_DEPTH = wfeb_pkg::TABLE_DEPTH_DEF,
    localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int FILL_W = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [wfeb_pkg::BSSID_W-1:0]       i_key,
    input  wire logic [wfeb_pkg::TLIM_W-1:0]        i_target_limit,
    input  wire logic                               i_commit,
    output wfeb_pkg::t_tbl_status                   o_status,
    output logic      [SLOT_W-1:0]                  o_slot,
    output logic      [FILL_W-1:0]                  o_fill
);

    localparam int CMP_W = (FILL_W > wfeb_pkg::TLIM_W) ? FILL_W : wfeb_pkg::TLIM_W;

    logic [wfeb_pkg::BSSID_W-1:0] r_table [TABLE_DEPTH];
    logic [FILL_W-1:0]            r_fill;
    logic [FILL_W-1:0]            n_fill;

    logic [TABLE_DEPTH-1:0] w_hit;
    logic [SLOT_W-1:0]      w_hit_slot;
    logic [CMP_W-1:0]       w_tlim;
    logic                   w_full;
    logic                   w_learn;

    // entries are unique, so at most one comparator fires
    always_comb begin
        w_hit_slot = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_hit[i] = (FILL_W'(i) < r_fill) && (r_table[i] == i_key);
            if (w_hit[i]) begin
                w_hit_slot = w_hit_slot | SLOT_W'(i);
            end
        end
    end

    always_comb begin
        if (CMP_W'(i_target_limit) > CMP_W'(TABLE_DEPTH)) begin
            w_tlim = CMP_W'(TABLE_DEPTH);
        end else begin
            w_tlim = CMP_W'(i_target_limit);
        end
        w_full  = CMP_W'(r_fill) >= w_tlim;
        w_learn = i_commit && !(|w_hit) && !w_full;
        n_fill  = w_learn ? r_fill + FILL_W'(1) : r_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_learn) begin
            r_table[r_fill[SLOT_W-1:0]] <= i_key;
        end
    end

    assign o_status.hit   = |w_hit;
    assign o_status.full  = w_full;
    assign o_status.learn = w_learn;
    assign o_slot = (|w_hit) ? w_hit_slot : r_fill[SLOT_W-1:0];
    assign o_fill = r_fill;

endmodule

`default_nettype wire

/* bench/testbench.sv */
// self-checking testbench of the 802.11 beacon and eapol frame filter
`timescale 1ns / 1ps

module testbench;
    import wfeb_pkg::*;

    // frame kinds the stimulus can build
    localparam int FK_BEACON = 0;
    localparam int FK_DATA   = 1;
    localparam int FK_WDS    = 2;
    localparam int FK_OTHER  = 3;
    localparam int FK_NOISE  = 4;

    // receiver stall patterns
    localparam int RX_OPEN     = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_MOSTLY   = 2;
    localparam int RX_PERIODIC = 3;

    localparam int POOL_N      = 24;
    localparam int LONG_HOLD   = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE      = 4;
    localparam int MAX_PRINTS  = 40;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              eof;
    } t_frame_byte;

    typedef struct packed {
        t_verdict               verdict;
        logic [LEN_W-1:0]       frame_len;
        logic [HDR_W-1:0]       hdr_bytes;
        logic [SLOT_OUT_W-1:0]  slot;
    } t_verdict_item;

    logic i_clk;
    logic i_rst_n;

    wfeb_in_if  in_ch ();
    wfeb_out_if out_ch ();
    wfeb_cfg_if cfg_ch ();

    wlan_frame_eapol_beacon_filter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // bytes waiting to be offered and verdicts waiting to arrive
    t_frame_byte   pend_q[$];
    t_verdict_item verdict_q[$];
    int pushed_cnt;
    int accepted_cnt;
    int err_cnt;
    int hold_reqs;

    // filter model state and its copy of the registers
    int                  frm_cnt;
    logic [FC_W-1:0]     frm_fc;
    logic [BSSID_W-1:0]  frm_bssid;
    logic [LLC_W-1:0]    frm_llc;
    logic [BSSID_W-1:0]  bssid_tbl [TABLE_DEPTH_DEF];
    int                  tbl_fill;
    logic [TLIM_W-1:0]   cfg_tlim;
    logic [LEN_W-1:0]    cfg_maxlen;

    logic [BSSID_W-1:0]  bssid_pool [POOL_N];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS)
            $display("mismatch %0s: got %0d expected %0d", what, got, want);
    endtask

    function automatic int pick_hdr(input int hp);
        return HDR_BASE + (hp[0] ? 2 : 0) + (hp[1] ? 4 : 0);
    endfunction

    // header length from frame control: qos is bit 7, ht control bit 15
    function automatic int data_hdr_bytes(input logic [FC_W-1:0] fc);
        return HDR_BASE + (fc[7] ? 2 : 0) + (fc[15] ? 4 : 0);
    endfunction

    // advance the filter model by one accepted byte, queue a verdict on the last one
    task automatic filter_byte(input logic [BYTE_W-1:0] b, input logic eof);
        int lim, pos, h, tl;
        t_verdict_item r;
        logic [1:0] ftype;
        logic [3:0] fsub;
        bit hit;
        lim = cfg_maxlen;
        if (lim > FRAME_MAX_DEF) lim = FRAME_MAX_DEF;
        if (lim > LIMIT_HARD_MAX) lim = LIMIT_HARD_MAX;
        // bytes past limit+1 are dropped and the count freezes
        if (frm_cnt < lim + 1) begin
            pos = frm_cnt;
            if (pos == 0) frm_fc[7:0] = b;
            else if (pos == 1) frm_fc[15:8] = b;
            if (pos >= BSSID_FIRST && pos <= BSSID_FIRST + 5)
                frm_bssid[8*(BSSID_FIRST+5-pos) +: 8] = b;
            if (pos >= 2) begin
                h = data_hdr_bytes(frm_fc);
                if (pos == h) frm_llc[31:24] = b;
                else if (pos == h + 1) frm_llc[23:16] = b;
                else if (pos == h + 6) frm_llc[15:8] = b;
                else if (pos == h + 7) frm_llc[7:0] = b;
            end
            frm_cnt++;
        end
        if (!eof) return;

        r.verdict   = VERDICT_SHORT;
        r.frame_len = LEN_W'(frm_cnt);
        r.hdr_bytes = '0;
        r.slot      = '0;
        ftype = frm_fc[3:2];
        fsub  = frm_fc[7:4];
        if (frm_cnt < MIN_FRAME) begin
            r.verdict = VERDICT_SHORT;
        end else if (frm_cnt > lim) begin
            r.verdict = VERDICT_TOO_LONG;
        end else if (ftype == FTYPE_MGMT && fsub == FSUB_BEACON) begin
            tl = cfg_tlim;
            if (tl > TABLE_DEPTH_DEF) tl = TABLE_DEPTH_DEF;
            hit = 1'b0;
            for (int i = 0; i < tbl_fill; i++) begin
                if (!hit && bssid_tbl[i] == frm_bssid) begin
                    hit = 1'b1;
                    r.slot = SLOT_OUT_W'(i);
                end
            end
            if (hit) begin
                r.verdict = VERDICT_BEACON;
            end else if (tbl_fill >= tl) begin
                r.verdict = VERDICT_TABLE_FULL;
            end else begin
                // learn the new bssid into the next free entry
                r.slot = SLOT_OUT_W'(tbl_fill);
                bssid_tbl[tbl_fill] = frm_bssid;
                tbl_fill++;
                r.verdict = VERDICT_BEACON;
            end
        end else if (ftype == FTYPE_DATA) begin
            if (frm_fc[8] && frm_fc[9]) begin
                r.verdict = VERDICT_WDS;
            end else begin
                h = data_hdr_bytes(frm_fc);
                r.hdr_bytes = HDR_W'(h);
                if (frm_cnt < h + LLC_LEN) r.verdict = VERDICT_NOT_EAPOL;
                else if (frm_llc == LLC_EAPOL) r.verdict = VERDICT_EAPOL;
                else r.verdict = VERDICT_NOT_EAPOL;
            end
        end else begin
            r.verdict = VERDICT_OTHER_TYPE;
        end
        verdict_q.push_back(r);
        frm_cnt   = 0;
        frm_fc    = '0;
        frm_bssid = '0;
        frm_llc   = '0;
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic eof);
        t_frame_byte it;
        it.b   = b;
        it.eof = eof;
        pend_q.push_back(it);
        pushed_cnt++;
    endtask

    // build one frame of a given kind with random content and queue its bytes
    task automatic gen_frame(input int kind, input int len, input logic [BSSID_W-1:0] bssid,
                             input bit llc_ok, input int hp, input bit with_eof);
        logic [7:0] fb[$];
        logic [7:0] fc0, fc1;
        logic [7:0] lv[4];
        int lp[4];
        int h, k, sel;
        for (int i = 0; i < len; i++) fb.push_back(8'($urandom_range(0, 255)));
        fc0 = 8'($urandom_range(0, 255));
        fc1 = 8'($urandom_range(0, 255));
        case (kind)
            FK_BEACON: fc0 = {FSUB_BEACON, FTYPE_MGMT, fc0[1:0]};
            FK_DATA, FK_WDS: begin
                fc0 = {hp[0], fc0[6:4], FTYPE_DATA, fc0[1:0]};
                fc1[7] = hp[1];
                if (kind == FK_WDS) fc1[1:0] = 2'b11;
                else if (fc1[1:0] == 2'b11) fc1[1:0] = 2'($urandom_range(0, 2));
            end
            FK_OTHER: begin
                sel = $urandom_range(0, 2);
                if (sel == 0) begin
                    // management frame that is not a beacon
                    fc0[3:2] = FTYPE_MGMT;
                    if (fc0[7:4] == FSUB_BEACON) fc0[7:4] = 4'h9;
                end else begin
                    fc0[3:2] = (sel == 1) ? 2'b01 : 2'b11;
                end
            end
            default: ;
        endcase
        if (kind != FK_NOISE) begin
            if (len > 0) fb[0] = fc0;
            if (len > 1) fb[1] = fc1;
        end
        if (kind == FK_BEACON) begin
            for (int j = 0; j < 6; j++)
                if (BSSID_FIRST + j < len) fb[BSSID_FIRST + j] = bssid[8*(5-j) +: 8];
        end
        if (kind == FK_DATA) begin
            h = pick_hdr(hp);
            lp[0] = h;     lp[1] = h + 1; lp[2] = h + 6; lp[3] = h + 7;
            lv[0] = 8'hAA; lv[1] = 8'hAA; lv[2] = 8'h88; lv[3] = 8'h8E;
            // a broken snap header has one of its four checked bytes changed
            k = llc_ok ? -1 : $urandom_range(0, 3);
            for (int j = 0; j < 4; j++)
                if (lp[j] < len)
                    fb[lp[j]] = lv[j] ^ ((j == k) ? 8'($urandom_range(1, 255)) : 8'h00);
        end
        for (int i = 0; i < len; i++) push_byte(fb[i], with_eof && (i == len - 1));
    endtask

    task automatic random_frames(input int budget);
        int used, r, hp, len;
        used = 0;
        while (used < budget) begin
            r  = $urandom_range(0, 99);
            hp = $urandom_range(0, 3);
            if (r < 40) begin
                len = $urandom_range(MIN_FRAME, 48);
                gen_frame(FK_BEACON, len, bssid_pool[$urandom_range(0, POOL_N - 1)], 1'b1, hp,
                          1'b1);
            end else if (r < 75) begin
                len = pick_hdr(hp) + LLC_LEN + $urandom_range(0, 12);
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(MIN_FRAME, pick_hdr(hp) + LLC_LEN - 1);
                gen_frame(FK_DATA, len, '0, $urandom_range(0, 9) != 0, hp, 1'b1);
            end else if (r < 83) begin
                len = $urandom_range(MIN_FRAME, 40);
                gen_frame(FK_WDS, len, '0, 1'b1, hp, 1'b1);
            end else if (r < 90) begin
                len = $urandom_range(MIN_FRAME, 40);
                gen_frame(FK_OTHER, len, '0, 1'b1, hp, 1'b1);
            end else begin
                len = $urandom_range(1, 60);
                gen_frame(FK_NOISE, len, '0, 1'b1, hp, 1'b1);
            end
            used += len;
        end
    endtask

    // register write, only issued while no verdict is outstanding
    task automatic cfg_write(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_TARGET_LIMIT) cfg_tlim = val[TLIM_W-1:0];
        else cfg_maxlen = val;
    endtask

    // wait until every queued byte is taken and every verdict is back, then settle
    task automatic drain();
        do @(posedge i_clk); while (accepted_cnt != pushed_cnt || verdict_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.frame_byte    = '0;
        in_ch.end_of_frame  = 1'b0;
        out_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_TARGET_LIMIT;
        cfg_ch.data         = '0;
        pushed_cnt   = 0;
        accepted_cnt = 0;
        err_cnt      = 0;
        hold_reqs    = 0;
        frm_cnt      = 0;
        frm_fc       = '0;
        frm_bssid    = '0;
        frm_llc      = '0;
        tbl_fill     = 0;
        cfg_tlim     = TARGET_LIMIT_RST;
        cfg_maxlen   = MAX_LEN_RST;
        bssid_pool[0] = '0;
        bssid_pool[1] = '1;
        for (int i = 2; i < POOL_N; i++)
            bssid_pool[i] = {16'($urandom_range(0, 65535)), 32'($urandom)};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: tiny table and short length limit so every verdict shows up quickly
        cfg_write(CFG_TARGET_LIMIT, 10'd2);
        cfg_write(CFG_MAX_FRAME_LENGTH, 10'd40);
        push_byte(8'h00, 1'b1);
        for (int i = 0; i < 23; i++) push_byte(8'hFF, i == 22);
        gen_frame(FK_BEACON, 24, bssid_pool[0], 1'b1, 0, 1'b1);
        gen_frame(FK_BEACON, 30, bssid_pool[1], 1'b1, 0, 1'b1);
        gen_frame(FK_BEACON, 28, bssid_pool[2], 1'b1, 0, 1'b1);
        gen_frame(FK_BEACON, 24, bssid_pool[0], 1'b1, 3, 1'b1);
        gen_frame(FK_DATA, 32, '0, 1'b1, 0, 1'b1);
        gen_frame(FK_DATA, 38, '0, 1'b1, 3, 1'b1);
        gen_frame(FK_DATA, 40, '0, 1'b1, 1, 1'b1);
        gen_frame(FK_WDS, 30, '0, 1'b1, 2, 1'b1);
        gen_frame(FK_DATA, 34, '0, 1'b0, 2, 1'b1);
        // data frame one byte short of holding the snap header
        gen_frame(FK_DATA, 31, '0, 1'b1, 0, 1'b1);
        gen_frame(FK_OTHER, 26, '0, 1'b1, 0, 1'b1);
        gen_frame(FK_NOISE, 41, '0, 1'b1, 0, 1'b1);
        gen_frame(FK_NOISE, 45, '0, 1'b1, 0, 1'b1);
        drain();

        // limit lowered below the count in the middle of a frame
        gen_frame(FK_DATA, 30, '0, 1'b1, 0, 1'b0);
        drain();
        cfg_write(CFG_MAX_FRAME_LENGTH, 10'd24);
        for (int i = 0; i < 3; i++) push_byte(8'($urandom_range(0, 255)), i == 2);
        drain();

        // length limit below the minimum frame: everything is short
        cfg_write(CFG_MAX_FRAME_LENGTH, 10'd0);
        gen_frame(FK_NOISE, 5, '0, 1'b1, 0, 1'b1);
        gen_frame(FK_BEACON, 30, bssid_pool[3], 1'b1, 0, 1'b1);
        drain();
        cfg_write(CFG_MAX_FRAME_LENGTH, 10'd10);
        gen_frame(FK_BEACON, 30, bssid_pool[3], 1'b1, 0, 1'b1);
        drain();

        // zero target limit and a length register above the hard clamp
        cfg_write(CFG_TARGET_LIMIT, 10'd0);
        cfg_write(CFG_MAX_FRAME_LENGTH, 10'd1023);
        gen_frame(FK_BEACON, 24, bssid_pool[0], 1'b1, 0, 1'b1);
        gen_frame(FK_BEACON, 24, bssid_pool[5], 1'b1, 0, 1'b1);
        gen_frame(FK_NOISE, 520, '0, 1'b1, 0, 1'b1);
        drain();
        // target limit above the table depth
        cfg_write(CFG_TARGET_LIMIT, 10'd31);
        gen_frame(FK_BEACON, 24, bssid_pool[2], 1'b1, 1, 1'b1);
        gen_frame(FK_BEACON, 26, bssid_pool[3], 1'b1, 2, 1'b1);
        drain();

        // random part, one register setting per phase
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    cfg_write(CFG_TARGET_LIMIT, 10'd16);
                    cfg_write(CFG_MAX_FRAME_LENGTH, 10'd512);
                end
                1: begin
                    cfg_write(CFG_TARGET_LIMIT, 10'd1);
                    cfg_write(CFG_MAX_FRAME_LENGTH, 10'd24);
                end
                2: begin
                    cfg_write(CFG_TARGET_LIMIT, 10'd31);
                    cfg_write(CFG_MAX_FRAME_LENGTH, 10'd1023);
                end
                3: begin
                    cfg_write(CFG_TARGET_LIMIT, 10'd0);
                    cfg_write(CFG_MAX_FRAME_LENGTH, 10'd64);
                end
                4: begin
                    cfg_write(CFG_TARGET_LIMIT, 10'($urandom_range(0, 31)));
                    cfg_write(CFG_MAX_FRAME_LENGTH, 10'($urandom_range(24, 200)));
                end
                default: begin
                    cfg_write(CFG_TARGET_LIMIT, 10'($urandom_range(0, 31)));
                    cfg_write(CFG_MAX_FRAME_LENGTH, 10'($urandom_range(0, 1023)));
                end
            endcase
            // receiver holds off for a long stretch while the sender keeps going
            if (p == 0) hold_reqs++;
            random_frames(90);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // byte driver: bursts of random length with random gaps in between
    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        t_frame_byte nxt;
        if (!i_rst_n) begin
            in_ch.valid        <= 1'b0;
            in_ch.frame_byte   <= '0;
            in_ch.end_of_frame <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            // model the byte the filter takes at this edge
            if (in_ch.valid && in_ch.ready) begin
                filter_byte(in_ch.frame_byte, in_ch.end_of_frame);
                accepted_cnt++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (pend_q.size() != 0) begin
                    nxt = pend_q.pop_front();
                    in_ch.valid        <= 1'b1;
                    in_ch.frame_byte   <= nxt.b;
                    in_ch.end_of_frame <= nxt.eof;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // verdict receiver: stall pattern changes every window, plus the long hold-off
    int hold_seen;
    int hold_left;
    int rx_mode;
    int rx_win;
    int rx_tick;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_seen = hold_reqs;
            hold_left = 0;
            rx_mode   = RX_OPEN;
            rx_win    = 0;
            rx_tick   = 0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = LONG_HOLD;
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            if (rx_win == 0) begin
                rx_mode = $urandom_range(RX_OPEN, RX_PERIODIC);
                rx_win  = $urandom_range(16, 96);
            end else begin
                rx_win--;
            end
            rx_tick++;
            case (rx_mode)
                RX_OPEN:     out_ch.ready <= 1'b1;
                RX_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
                RX_MOSTLY:   out_ch.ready <= ($urandom_range(0, 9) != 0);
                default:     out_ch.ready <= (rx_tick % 3 != 0);
            endcase
        end
    end

    // verdict checker: each taken item against the oldest expectation
    always @(posedge i_clk) begin
        t_verdict_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("verdict with none expected", int'(out_ch.verdict), -1);
            end else begin
                want = verdict_q.pop_front();
                if (out_ch.verdict !== want.verdict)
                    report_mismatch("verdict", int'(out_ch.verdict), int'(want.verdict));
                if (out_ch.frame_length !== want.frame_len)
                    report_mismatch("frame_length", int'(out_ch.frame_length),
                                    int'(want.frame_len));
                if (out_ch.header_length !== want.hdr_bytes)
                    report_mismatch("header_length", int'(out_ch.header_length),
                                    int'(want.hdr_bytes));
                if (out_ch.table_slot !== want.slot)
                    report_mismatch("table_slot", int'(out_ch.table_slot), int'(want.slot));
            end
        end
    end

    // watchdog: too long without any handshake on any channel
    int idle_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/wfeb_pkg.sv
rtl/core/wfeb_if.sv
rtl/core/wfeb_bssid_table.sv
rtl/core/wlan_frame_eapol_beacon_filter.sv
bench/testbench.sv
